// ===== hdl/qstp_pkg.sv =====
`timescale 1ns / 1ps

package qstp_pkg;

  // Default width of one raw quaternion component.
  localparam int COMP_WIDTH_DEF = 24;

  // Width of one component code and its search counter.
  localparam int CODE_WIDTH = 10;

  // Cycles from an accepted start to the result strobe.
  localparam int PIPE_LATENCY = 14;

  // Dropped component (w,x,y,z order) to its index in x,y,z,w order.
  localparam logic [1:0] DROP_TO_XYZW [4] = '{2'd3, 2'd0, 2'd1, 2'd2};

  // Kept components (w,x,y,z indices) for each dropped index in x,y,z,w order.
  localparam logic [1:0] KEEP_SEL [4][3] = '{
    '{2'd2, 2'd3, 2'd0},
    '{2'd1, 2'd3, 2'd0},
    '{2'd1, 2'd2, 2'd0},
    '{2'd1, 2'd2, 2'd3}
  };

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] slot;
    logic [2:0] neg;
    logic [2:0] zero;
  } qstp_ctl_t;

endpackage

// ===== hdl/quaternion_smallest_three_pack.sv =====
`timescale 1ns / 1ps
// A taken start passes the front stages, the search stages and the packing register before it strobes on done_o.
// Throughput: one quaternion per cycle; busy stays low, every start is taken.
// The rate is set by the fully pipelined datapath: three front stages, ten search stages
// (one code bit each) and one packing stage.
// Reset: rst_ni clears all valid bits at once, so items in flight are dropped; the receiver cannot stall.

module quaternion_smallest_three_pack import qstp_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_z_i,
  output logic                              done_o,
  output logic [31:0]                       packed_rotation_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int TW = 2 * W + 12;
  localparam int CW = 2 * W + 23;

  // The pipeline never stalls, so a start is always taken.
  assign busy = 1'b0;

  // The front end forms magnitudes, squares, the sum of squares S, the largest
  // component and the bound 1023^2*c^2 for each of the three kept components.
  qstp_ctl_t                  ctl   [CODE_WIDTH+1];
  logic [SW-1:0]              s     [CODE_WIDTH+1];
  logic [2:0][CW-1:0]         rhs   [CODE_WIDTH+1];
  logic [2:0][CW-1:0]         u     [CODE_WIDTH+1];
  logic [2:0][TW-1:0]         t     [CODE_WIDTH+1];
  logic [2:0][CODE_WIDTH-1:0] m     [CODE_WIDTH+1];

  qstp_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start),
    .comp_w_i (comp_w_i),
    .comp_x_i (comp_x_i),
    .comp_y_i (comp_y_i),
    .comp_z_i (comp_z_i),
    .ctl_o    (ctl[0]),
    .s_o      (s[0]),
    .rhs_o    (rhs[0])
  );

  assign u[0] = '0;
  assign t[0] = '0;
  assign m[0] = '0;

  // Each search stage decides one bit of m, most significant first. A positive
  // component keeps the largest m with 2*m^2*S <= bound; a negative one keeps the
  // largest m with 2*m^2*S < bound, and its code uses m+1. The running products
  // m*S and m^2*S are updated with shifts and adds, so no stage needs a multiplier.
  for (genvar g = 0; g < CODE_WIDTH; g++) begin : g_search
    qstp_search_stage #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .BIT             (CODE_WIDTH - 1 - g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .s_i    (s[g]),
      .rhs_i  (rhs[g]),
      .u_i    (u[g]),
      .t_i    (t[g]),
      .m_i    (m[g]),
      .ctl_o  (ctl[g+1]),
      .s_o    (s[g+1]),
      .rhs_o  (rhs[g+1]),
      .u_o    (u[g+1]),
      .t_o    (t[g+1]),
      .m_o    (m[g+1])
    );
  end

  // Final stage: turn each search result into its code and pack the word.
  // A zero component, and every component of a zero quaternion, codes as 512.
  // A positive value that reaches 1024 or more is clamped to 1023.
  qstp_ctl_t                  cf;
  logic [2:0][CODE_WIDTH-1:0] code;
  logic [CODE_WIDTH:0]        up;
  logic [31:0]                word_d;

  assign cf = ctl[CODE_WIDTH];

  always_comb begin
    up = '0;
    for (int l = 0; l < 3; l++) begin
      if (cf.zero[l]) begin
        code[l] = CODE_WIDTH'(512);
      end else if (cf.neg[l]) begin
        code[l] = CODE_WIDTH'((CODE_WIDTH+1)'(512) - (CODE_WIDTH+1)'(m[CODE_WIDTH][l])
                  - (CODE_WIDTH+1)'(1));
      end else begin
        up = (CODE_WIDTH+1)'(512) + (CODE_WIDTH+1)'(m[CODE_WIDTH][l]);
        code[l] = up[CODE_WIDTH] ? {CODE_WIDTH{1'b1}} : up[CODE_WIDTH-1:0];
      end
    end
    word_d = {cf.slot, code[2], code[1], code[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    packed_rotation_o <= word_d;
  end

endmodule

// ===== hdl/qstp_front.sv =====
`timescale 1ns / 1ps

module qstp_front import qstp_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]     comp_z_i,
  output qstp_ctl_t                             ctl_o,
  output logic [2*COMPONENT_WIDTH+1:0]          s_o,
  output logic [2:0][2*COMPONENT_WIDTH+22:0]    rhs_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int SQ = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam int CW = 2 * W + 23;

  logic [3:0][W-1:0] comp;
  assign comp = {comp_z_i, comp_y_i, comp_x_i, comp_w_i};

  // Stage 1: magnitudes and signs.
  logic            v1_q;
  logic [3:0][W-1:0] mag_q, mag_d;
  logic [3:0]      neg1_q, neg1_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg1_d[i] = comp[i][W-1];
      mag_d[i]  = neg1_d[i] ? (~comp[i] + W'(1)) : comp[i];
    end
  end

  // Stage 2: squares and the largest magnitude.
  logic             v2_q;
  logic [3:0][SQ-1:0] sq_q, sq_d;
  logic [3:0]       neg2_q;
  logic [1:0]       big_q, big_d;
  logic             flip_q, flip_d;

  always_comb begin
    big_d = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (mag_q[i] > mag_q[big_d]) begin
        big_d = 2'(i);
      end
    end
    flip_d = neg1_q[big_d] && (mag_q[big_d] != '0);
    for (int i = 0; i < 4; i++) begin
      sq_d[i] = SQ'(mag_q[i]) * SQ'(mag_q[i]);
    end
  end

  // Stage 3: sum of squares, selection of kept components and their bounds.
  qstp_ctl_t          ctl_d;
  logic [SW-1:0]      s_d;
  logic [2:0][CW-1:0] rhs_d;
  logic [1:0]         k;
  logic [CW-1:0]      msq;

  always_comb begin
    s_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
    ctl_d.valid = v2_q;
    ctl_d.slot  = DROP_TO_XYZW[big_q];
    k   = 2'd0;
    msq = '0;
    for (int j = 0; j < 3; j++) begin
      k   = KEEP_SEL[ctl_d.slot][j];
      msq = CW'(sq_q[k]);
      // 1023^2 = 2^20 - 2^11 + 1
      rhs_d[j]      = (msq << 20) - (msq << 11) + msq;
      ctl_d.neg[j]  = neg2_q[k] ^ flip_q;
      ctl_d.zero[j] = (sq_q[k] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ctl_o <= '0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      ctl_o <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg1_q <= neg1_d;
    sq_q   <= sq_d;
    neg2_q <= neg1_q;
    big_q  <= big_d;
    flip_q <= flip_d;
    s_o    <= s_d;
    rhs_o  <= rhs_d;
  end

endmodule

// ===== hdl/qstp_search_stage.sv =====
`timescale 1ns / 1ps

module qstp_search_stage import qstp_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF,
  parameter int BIT = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  qstp_ctl_t                             ctl_i,
  input  logic [2*COMPONENT_WIDTH+1:0]          s_i,
  input  logic [2:0][2*COMPONENT_WIDTH+22:0]    rhs_i,
  input  logic [2:0][2*COMPONENT_WIDTH+22:0]    u_i,
  input  logic [2:0][2*COMPONENT_WIDTH+11:0]    t_i,
  input  logic [2:0][CODE_WIDTH-1:0]            m_i,
  output qstp_ctl_t                             ctl_o,
  output logic [2*COMPONENT_WIDTH+1:0]          s_o,
  output logic [2:0][2*COMPONENT_WIDTH+22:0]    rhs_o,
  output logic [2:0][2*COMPONENT_WIDTH+22:0]    u_o,
  output logic [2:0][2*COMPONENT_WIDTH+11:0]    t_o,
  output logic [2:0][CODE_WIDTH-1:0]            m_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int TW = 2 * W + 12;
  localparam int CW = 2 * W + 23;

  // Trying bit BIT of m: (m+2^b)^2*S = m^2*S + 2^(b+1)*m*S + 2^(2b)*S.
  logic [2:0][CW-1:0]         u_d;
  logic [2:0][TW-1:0]         t_d;
  logic [2:0][CODE_WIDTH-1:0] m_d;
  logic [CW-1:0]              u_try, two_u;
  logic [TW-1:0]              t_try;
  logic                       acc;

  always_comb begin
    u_try = '0;
    two_u = '0;
    t_try = '0;
    acc   = 1'b0;
    for (int l = 0; l < 3; l++) begin
      u_try = u_i[l] + (CW'(t_i[l]) << (BIT + 1)) + (CW'(s_i) << (2 * BIT));
      t_try = t_i[l] + (TW'(s_i) << BIT);
      two_u = u_try << 1;
      acc   = ctl_i.neg[l] ? (two_u < rhs_i[l]) : (two_u <= rhs_i[l]);
      u_d[l] = acc ? u_try : u_i[l];
      t_d[l] = acc ? t_try : t_i[l];
      m_d[l] = acc ? (m_i[l] | (CODE_WIDTH'(1) << BIT)) : m_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_o   <= s_i;
    rhs_o <= rhs_i;
    u_o   <= u_d;
    t_o   <= t_d;
    m_o   <= m_d;
  end

endmodule

// ===== hdl/qstp_checker.sv =====
`timescale 1ns / 1ps

module qstp_checker import qstp_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic signed [COMPONENT_WIDTH-1:0] comp_w_i,
  input logic signed [COMPONENT_WIDTH-1:0] comp_x_i,
  input logic signed [COMPONENT_WIDTH-1:0] comp_y_i,
  input logic signed [COMPONENT_WIDTH-1:0] comp_z_i,
  input logic                              done_o,
  input logic [31:0]                       packed_rotation_o
);

  logic all_zero;
  assign all_zero = (comp_w_i == '0) && (comp_x_i == '0) && (comp_y_i == '0)
                    && (comp_z_i == '0);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised on a pipeline that never stalls");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##PIPE_LATENCY done_o)
    else $error("accepted start produced no result");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, PIPE_LATENCY))
    else $error("result without a matching start");

  a_zero_quat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && all_zero) |-> ##PIPE_LATENCY (packed_rotation_o == 32'hE008_0200))
    else $error("zero quaternion not packed as index w with mid codes");

endmodule

bind quaternion_smallest_three_pack qstp_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_qstp_checker (.*);
